/* hdl/mic_pkg.sv */
// Shared types and constants for the word-addressed MIPS32 integer core.
// No dependencies; compiled first.
package mic_pkg;

  localparam int unsigned MemDepthDef = 16384;  // power of two, 256 .. 1048576

  localparam int unsigned TextW  = 14;
  localparam int unsigned LimitW = 15;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned PcOutW = 14;

  typedef enum logic [1:0] {
    CmdWrite   = 2'd0,
    CmdExec    = 2'd1,
    CmdRestart = 2'd2
  } mic_cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTextStart  = 2'd0,
    CfgExecLimit  = 2'd1,
    CfgStackLimit = 2'd2
  } mic_cfg_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StService = 3'd1,
    StExit    = 3'd2,
    StUnsup   = 3'd3,
    StJumpOob = 3'd4,
    StEnd     = 3'd5
  } mic_status_e;

  typedef enum logic [2:0] {
    SIdle, SFetch, SExec, SLoad, SMul, SDiv, SDone
  } mic_state_e;

  // primary opcodes
  localparam logic [5:0] OpSpecial = 6'd0;
  localparam logic [5:0] OpJ       = 6'd2;
  localparam logic [5:0] OpJal     = 6'd3;
  localparam logic [5:0] OpBeq     = 6'd4;
  localparam logic [5:0] OpBne     = 6'd5;
  localparam logic [5:0] OpAddi    = 6'd8;
  localparam logic [5:0] OpAddiu   = 6'd9;
  localparam logic [5:0] OpSlti    = 6'd10;
  localparam logic [5:0] OpSltiu   = 6'd11;
  localparam logic [5:0] OpAndi    = 6'd12;
  localparam logic [5:0] OpOri     = 6'd13;
  localparam logic [5:0] OpXori    = 6'd14;
  localparam logic [5:0] OpLui     = 6'd15;
  localparam logic [5:0] OpLw      = 6'd35;
  localparam logic [5:0] OpSw      = 6'd43;

  // SPECIAL function codes
  localparam logic [5:0] FnSll     = 6'd0;
  localparam logic [5:0] FnSrl     = 6'd2;
  localparam logic [5:0] FnSra     = 6'd3;
  localparam logic [5:0] FnSllv    = 6'd4;
  localparam logic [5:0] FnSrlv    = 6'd6;
  localparam logic [5:0] FnSrav    = 6'd7;
  localparam logic [5:0] FnJr      = 6'd8;
  localparam logic [5:0] FnJalr    = 6'd9;
  localparam logic [5:0] FnSyscall = 6'd12;
  localparam logic [5:0] FnMfhi    = 6'd16;
  localparam logic [5:0] FnMthi    = 6'd17;
  localparam logic [5:0] FnMflo    = 6'd18;
  localparam logic [5:0] FnMtlo    = 6'd19;
  localparam logic [5:0] FnMult    = 6'd24;
  localparam logic [5:0] FnMultu   = 6'd25;
  localparam logic [5:0] FnDiv     = 6'd26;
  localparam logic [5:0] FnDivu    = 6'd27;
  localparam logic [5:0] FnAdd     = 6'd32;
  localparam logic [5:0] FnAddu    = 6'd33;
  localparam logic [5:0] FnSub     = 6'd34;
  localparam logic [5:0] FnSubu    = 6'd35;
  localparam logic [5:0] FnAnd     = 6'd36;
  localparam logic [5:0] FnOr      = 6'd37;
  localparam logic [5:0] FnXor     = 6'd38;
  localparam logic [5:0] FnNor     = 6'd39;
  localparam logic [5:0] FnSlt     = 6'd42;
  localparam logic [5:0] FnSltu    = 6'd43;

  localparam logic [4:0] RegV0 = 5'd2;
  localparam logic [4:0] RegA0 = 5'd4;
  localparam logic [4:0] RegSp = 5'd29;
  localparam logic [4:0] RegRa = 5'd31;

  localparam logic [31:0] SvcExit     = 32'd10;
  localparam logic [31:0] SvcExitCode = 32'd17;

  typedef struct packed {
    logic       en;
    logic [4:0] ra;
    logic [4:0] rb;
  } mic_gpr_rd_t;

  typedef struct packed {
    logic        we;
    logic        clr;
    logic [4:0]  wa;
    logic [31:0] wd;
  } mic_gpr_wr_t;

  typedef struct packed {
    logic        start;
    logic        sgn;
    logic [31:0] a;
    logic [31:0] b;
  } mic_div_req_t;

endpackage

/* hdl/mic_if.sv */
// Channel interfaces: command input, result output and register write port.
// Field widths follow mic_pkg.
interface mic_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [13:0] word_index;
  logic [31:0] word_value;
  modport source (output valid, command, word_index, word_value, input ready);
  modport sink (input valid, command, word_index, word_value, output ready);
endinterface

interface mic_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [13:0] next_pc;
  logic [31:0] service_code;
  logic [31:0] service_arg;
  modport source (output valid, status, next_pc, service_code, service_arg, input ready);
  modport sink (input valid, status, next_pc, service_code, service_arg, output ready);
endinterface

interface mic_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/mic_gpr.sv */
// General register file: 32x32 memory, two registered read ports, one write.
// Per-entry valid bits give the zero contents after reset or restart. Uses mic_pkg.
module mic_gpr (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mic_pkg::mic_gpr_rd_t rd_i,
  input  mic_pkg::mic_gpr_wr_t wr_i,
  output logic [31:0]          rdata_a_o,
  output logic [31:0]          rdata_b_o
);
  import mic_pkg::*;

  logic [31:0] mem [32];
  logic [31:0] vld_q, vld_d;
  logic [31:0] data_a_q, data_b_q;
  logic        vld_a_q, vld_b_q;
  logic        wen;

  assign wen = wr_i.we && (wr_i.wa != 5'd0);

  // restart clears every entry, a write in the same beat sets its own bit again
  always_comb begin
    vld_d = wr_i.clr ? '0 : vld_q;
    if (wen) begin
      vld_d[wr_i.wa] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) begin
      mem[wr_i.wa] <= wr_i.wd;
    end
    if (rd_i.en) begin
      data_a_q <= mem[rd_i.ra];
      data_b_q <= mem[rd_i.rb];
      vld_a_q  <= vld_q[rd_i.ra];
      vld_b_q  <= vld_q[rd_i.rb];
    end
  end

  assign rdata_a_o = vld_a_q ? data_a_q : 32'd0;
  assign rdata_b_o = vld_b_q ? data_b_q : 32'd0;

endmodule

/* hdl/mic_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Signed operands are divided as magnitudes and fixed up at the end. Uses mic_pkg.
module mic_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mic_pkg::mic_div_req_t req_i,
  output logic                  done_o,
  output logic [31:0]           quo_o,
  output logic [31:0]           rem_o
);
  import mic_pkg::*;

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [31:0] rem_q, quo_q, ub_q;
  logic        nq_q, nr_q, zero_q;
  logic [32:0] rem_sh, diff;
  logic [31:0] ua, ub;

  assign ua     = (req_i.sgn && req_i.a[31]) ? (32'd0 - req_i.a) : req_i.a;
  assign ub     = (req_i.sgn && req_i.b[31]) ? (32'd0 - req_i.b) : req_i.b;
  assign rem_sh = {rem_q, quo_q[31]};
  assign diff   = rem_sh - {1'b0, ub_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      quo_q  <= ua;
      ub_q   <= ub;
      nq_q   <= req_i.sgn && (req_i.a[31] ^ req_i.b[31]);
      nr_q   <= req_i.sgn && req_i.a[31];
      zero_q <= (req_i.b == 32'd0);
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= rem_sh[31:0];
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? 32'd0 : (nq_q ? (32'd0 - quo_q) : quo_q);
  assign rem_o  = zero_q ? 32'd0 : (nr_q ? (32'd0 - rem_q) : rem_q);

endmodule

/* hdl/mips_integer_core_step_top.sv */
// Word-addressed MIPS32 integer core, one command beat in, one result beat out.
// Write, restart and halted execute go straight to result; an execute runs fetch,
// register read, execute, result; lw, mult and div add a load, mult or div state.
// One command at a time; a finished result waits in the output register meanwhile.
// Reset (async, active low) clears pc, hi, lo, stop flag and registers and returns the
// config to its defaults; word memory holds nothing defined until written.
// Depends on mic_pkg, mic_if.
module mips_integer_core_step_top #(
  parameter int unsigned MEM_DEPTH = mic_pkg::MemDepthDef  // power of two
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mic_in_if.sink    in_i,
  mic_out_if.source out_o,
  mic_cfg_if.sink   cfg_i
);
  import mic_pkg::*;

  localparam int unsigned AW = $clog2(MEM_DEPTH);

  // configuration
  logic [TextW-1:0]  text_start_q;
  logic [LimitW-1:0] exec_limit_q, stack_limit_q;

  // architectural state
  mic_state_e  state_q, state_d;
  logic [AW-1:0] pc_q, pc_d;
  logic [31:0] hi_q, hi_d, lo_q, lo_d;
  logic        stopped_q, stopped_d;
  logic [31:0] inst_q, inst_d;

  // pending result
  mic_status_e st_q, st_d;
  logic [31:0] code_q, code_d, arg_q, arg_d;

  // output register
  logic              out_valid_q;
  mic_status_e       out_st_q;
  logic [PcOutW-1:0] out_pc_q;
  logic [31:0]       out_code_q, out_arg_q;
  logic              out_load;

  // word memory port
  logic [31:0]   wmem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [31:0]   mem_wd, mem_rdata_q;

  // register file and divider
  mic_gpr_rd_t  gpr_rd;
  mic_gpr_wr_t  gpr_wr;
  logic [31:0]  gpr_a, gpr_b;
  mic_div_req_t div_req;
  logic         div_done;
  logic [31:0]  div_quo, div_rem;

  // decode of the held instruction
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] simm, zimm, ls_sum;
  logic [AW-1:0] pc_inc, br_tgt, ls_addr;
  logic [25:0] tgt;
  logic        fetch_sys;
  logic signed [65:0] prod;

  assign op     = inst_q[31:26];
  assign rt     = inst_q[20:16];
  assign rd     = inst_q[15:11];
  assign sh     = inst_q[10:6];
  assign fn     = inst_q[5:0];
  assign tgt    = inst_q[25:0];
  assign zimm   = {16'd0, inst_q[15:0]};
  assign simm   = {{16{inst_q[15]}}, inst_q[15:0]};
  assign pc_inc = pc_q + AW'(1);
  assign br_tgt = pc_inc + simm[AW-1:0];
  assign ls_sum = gpr_a + simm;
  assign ls_addr = ls_sum[AW+1:2];

  // syscall reads v0 and a0 in place of rs and rt
  assign fetch_sys = (mem_rdata_q[31:26] == OpSpecial) && (mem_rdata_q[5:0] == FnSyscall);

  // one 33x33 signed product; mult sign-extends, multu zero-extends
  assign prod = $signed({(fn == FnMult) & gpr_a[31], gpr_a})
              * $signed({(fn == FnMult) & gpr_b[31], gpr_b});

  mic_gpr u_gpr (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_i      (gpr_rd),
    .wr_i      (gpr_wr),
    .rdata_a_o (gpr_a),
    .rdata_b_o (gpr_b)
  );

  mic_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quo_o  (div_quo),
    .rem_o  (div_rem)
  );

  // word memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wmem[mem_wa] <= mem_wd;
    end
    mem_rdata_q <= wmem[mem_ra];
  end

  // sequencer
  always_comb begin
    logic [AW-1:0] nxt;
    logic          upd;
    nxt       = pc_inc;
    upd       = 1'b1;
    state_d   = state_q;
    pc_d      = pc_q;
    hi_d      = hi_q;
    lo_d      = lo_q;
    stopped_d = stopped_q;
    inst_d    = inst_q;
    st_d      = st_q;
    code_d    = code_q;
    arg_d     = arg_q;
    gpr_rd    = '0;
    gpr_wr    = '0;
    mem_we    = 1'b0;
    mem_wa    = ls_addr;
    mem_wd    = gpr_b;
    mem_ra    = pc_q;
    div_req   = '{start: 1'b0, sgn: (fn == FnDiv), a: gpr_a, b: gpr_b};
    out_load  = 1'b0;
    in_i.ready = 1'b0;

    unique case (state_q)
      SIdle: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          st_d    = StOk;
          code_d  = '0;
          arg_d   = '0;
          state_d = SDone;
          unique case (in_i.command)
            CmdWrite: begin
              mem_we = 1'b1;
              mem_wa = AW'(in_i.word_index);
              mem_wd = in_i.word_value;
            end
            CmdExec: begin
              if (stopped_q) begin
                st_d = StEnd;
              end else if (32'(pc_q) >= 32'(exec_limit_q)) begin
                stopped_d = 1'b1;
                st_d      = StEnd;
              end else begin
                state_d = SFetch;  // memory read of pc issued this edge
              end
            end
            CmdRestart: begin
              gpr_wr    = '{we: 1'b1, clr: 1'b1, wa: RegSp,
                            wd: 32'(stack_limit_q) - 32'd1};
              hi_d      = '0;
              lo_d      = '0;
              pc_d      = AW'(text_start_q);
              stopped_d = 1'b0;
            end
            default: ;
          endcase
        end
      end

      SFetch: begin
        inst_d    = mem_rdata_q;
        gpr_rd.en = 1'b1;
        gpr_rd.ra = fetch_sys ? RegV0 : mem_rdata_q[25:21];
        gpr_rd.rb = fetch_sys ? RegA0 : mem_rdata_q[20:16];
        state_d   = SExec;
      end

      SExec: begin
        state_d = SDone;
        if (op == OpSpecial) begin
          gpr_wr.wa = rd;
          unique case (fn)
            FnSll:  begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_b << sh; end
            FnSrl:  begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_b >> sh; end
            FnSra:  begin gpr_wr.we = 1'b1; gpr_wr.wd = 32'($signed(gpr_b) >>> sh); end
            FnSllv: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_b << gpr_a[4:0]; end
            FnSrlv: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_b >> gpr_a[4:0]; end
            FnSrav: begin
              gpr_wr.we = 1'b1;
              gpr_wr.wd = 32'($signed(gpr_b) >>> gpr_a[4:0]);
            end
            FnJr:   nxt = gpr_a[AW-1:0];
            FnJalr: begin
              gpr_wr.we = 1'b1;
              gpr_wr.wd = 32'(pc_inc);
              nxt       = gpr_a[AW-1:0];
            end
            FnSyscall: begin
              code_d = gpr_a;
              if (gpr_a == SvcExit) begin
                stopped_d = 1'b1;
                st_d      = StExit;
              end else if (gpr_a == SvcExitCode) begin
                arg_d     = gpr_b;
                stopped_d = 1'b1;
                st_d      = StExit;
              end else begin
                arg_d = gpr_b;
                st_d  = StService;
              end
            end
            FnMfhi: begin gpr_wr.we = 1'b1; gpr_wr.wd = hi_q; end
            FnMthi: hi_d = gpr_a;
            FnMflo: begin gpr_wr.we = 1'b1; gpr_wr.wd = lo_q; end
            FnMtlo: lo_d = gpr_a;
            FnMult, FnMultu: state_d = SMul;
            FnDiv, FnDivu: begin
              div_req.start = 1'b1;
              state_d       = SDiv;
            end
            FnAdd, FnAddu: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a + gpr_b; end
            FnSub, FnSubu: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a - gpr_b; end
            FnAnd:  begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a & gpr_b; end
            FnOr:   begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a | gpr_b; end
            FnXor:  begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a ^ gpr_b; end
            FnNor:  begin gpr_wr.we = 1'b1; gpr_wr.wd = ~(gpr_a | gpr_b); end
            FnSlt:  begin
              gpr_wr.we = 1'b1;
              gpr_wr.wd = {31'd0, $signed(gpr_a) < $signed(gpr_b)};
            end
            FnSltu: begin gpr_wr.we = 1'b1; gpr_wr.wd = {31'd0, gpr_a < gpr_b}; end
            default: begin
              upd       = 1'b0;
              stopped_d = 1'b1;
              st_d      = StUnsup;
            end
          endcase
        end else begin
          gpr_wr.wa = rt;
          unique case (op)
            OpJ: begin
              if (32'(tgt) >= 32'(stack_limit_q)) begin
                upd       = 1'b0;
                stopped_d = 1'b1;
                st_d      = StJumpOob;
              end else begin
                nxt = tgt[AW-1:0];
              end
            end
            OpJal: begin
              gpr_wr.we = 1'b1;
              gpr_wr.wa = RegRa;
              gpr_wr.wd = 32'(pc_inc);
              nxt       = tgt[AW-1:0];
            end
            OpBeq: if (gpr_a == gpr_b) nxt = br_tgt;
            OpBne: if (gpr_a != gpr_b) nxt = br_tgt;
            OpAddi, OpAddiu: begin gpr_wr.we = 1'b1; gpr_wr.wd = ls_sum; end
            OpSlti: begin
              gpr_wr.we = 1'b1;
              gpr_wr.wd = {31'd0, $signed(gpr_a) < $signed(simm)};
            end
            OpSltiu: begin gpr_wr.we = 1'b1; gpr_wr.wd = {31'd0, gpr_a < simm}; end
            OpAndi: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a & zimm; end
            OpOri:  begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a | zimm; end
            OpXori: begin gpr_wr.we = 1'b1; gpr_wr.wd = gpr_a ^ zimm; end
            OpLui:  begin gpr_wr.we = 1'b1; gpr_wr.wd = {inst_q[15:0], 16'd0}; end
            OpLw: begin
              mem_ra  = ls_addr;
              state_d = SLoad;
            end
            OpSw: mem_we = 1'b1;
            default: begin
              upd       = 1'b0;
              stopped_d = 1'b1;
              st_d      = StUnsup;
            end
          endcase
        end
        if (upd) begin
          pc_d = nxt;
        end
      end

      SLoad: begin
        gpr_wr  = '{we: 1'b1, clr: 1'b0, wa: rt, wd: mem_rdata_q};
        state_d = SDone;
      end

      SMul: begin
        hi_d    = prod[63:32];
        lo_d    = prod[31:0];
        state_d = SDone;
      end

      SDiv: begin
        if (div_done) begin
          hi_d    = div_rem;
          lo_d    = div_quo;
          state_d = SDone;
        end
      end

      SDone: begin
        // hand the result over as soon as the output register is free
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end

      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      pc_q        <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      stopped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      hi_q      <= hi_d;
      lo_q      <= lo_d;
      stopped_q <= stopped_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inst_q <= inst_d;
    st_q   <= st_d;
    code_q <= code_d;
    arg_q  <= arg_d;
    if (out_load) begin
      out_st_q   <= st_q;
      out_pc_q   <= PcOutW'(pc_q);
      out_code_q <= code_q;
      out_arg_q  <= arg_q;
    end
  end

  // register writes; always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_start_q  <= '0;
      exec_limit_q  <= LimitW'(16384);
      stack_limit_q <= LimitW'(16384);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgTextStart:  text_start_q  <= cfg_i.data[TextW-1:0];
        CfgExecLimit:  exec_limit_q  <= cfg_i.data;
        CfgStackLimit: stack_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_st_q;
  assign out_o.next_pc      = out_pc_q;
  assign out_o.service_code = out_code_q;
  assign out_o.service_arg  = out_arg_q;

endmodule

/* hdl/mic_chk.sv */
// Port-level checks for mips_integer_core_step_top, bound to every instance.
// Depends on mic_pkg and the top level.
module mic_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [31:0] out_code,
  input logic [31:0] out_arg
);
  import mic_pkg::*;

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(out_status) && $stable(out_code)
                                && $stable(out_arg))
    else $error("result beat changed while stalled");

  // one command in flight: no beat taken the cycle after a beat
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("command accepted back to back");

  // service fields only carry data for syscall outcomes
  a_svc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_status != StService && out_status != StExit
      |-> out_code == 32'd0 && out_arg == 32'd0)
    else $error("service fields set outside a syscall");

endmodule

bind mips_integer_core_step_top mic_chk u_mic_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_i.valid),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .out_status (out_o.status),
  .out_code   (out_o.service_code),
  .out_arg    (out_o.service_arg)
);
